// ===== hw/rtl/scfs_pkg.sv =====
// shared types, codes and constants of the sprite clip frame sequencer
`default_nettype none
package scfs_pkg;

  localparam int MAX_FRAMES_DEF = 256;
  localparam int HOP_LIMIT_DEF  = 1024;

  // frame position is as wide as the frame count register
  localparam int POS_W = 9;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_ADVANCE = 2'd1;
  localparam logic [1:0] CMD_SETPOS  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DELTA_BIG = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_LIMIT     = 2'd3;

  localparam logic [23:0] DELTA_MAX_US = 24'd10000000;
  localparam logic [9:0]  US_PER_MS    = 10'd1000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  entry_index;
    logic [15:0] length_ms;
    logic [7:0]  event_code;
    logic [23:0] delta_us;
    logic [7:0]  position_index;
    logic        start_playing;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  current_frame;
    logic [10:0] transitions;
    logic        frame_stepped;
    logic        wrapped;
    logic        is_playing;
    logic [7:0]  fired_event;
    logic [31:0] loops_completed;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic decode;
    logic load_wr;
    logic set_pos;
    logic adv_begin;
    logic mul;
    logic step;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_load;
    logic is_setpos;
    logic adv_run;
    logic step_ok;
    logic out_busy;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/scfs_if.sv =====
// valid/ready channel interfaces for input items and results
`default_nettype none
interface scfs_in_if;
  logic               valid;
  logic               ready;
  scfs_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scfs_out_if;
  logic                valid;
  logic                ready;
  scfs_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/scfs_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module scfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/scfs_datapath.sv =====
// datapath: item register, clip table, play state and result register
`default_nettype none
module scfs_datapath #(
  parameter int MAX_FRAMES = scfs_pkg::MAX_FRAMES_DEF,
  parameter int HOP_LIMIT  = scfs_pkg::HOP_LIMIT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire scfs_pkg::dp_cmd_t   cmd,
  output scfs_pkg::dp_sts_t        sts,
  input  wire scfs_pkg::in_item_t  in_data,
  input  wire logic [8:0]          frame_count,
  input  wire logic                looping,
  output scfs_pkg::out_item_t      out_data,
  output logic                     out_valid,
  input  wire logic                out_ready
);
  import scfs_pkg::*;

  localparam int AW = $clog2(MAX_FRAMES);
  localparam int TW = $clog2(HOP_LIMIT + 1);
  localparam logic [POS_W-1:0] CLIP_CAP =
    (MAX_FRAMES > 511) ? 9'd511 : POS_W'(MAX_FRAMES);
  localparam logic [TW-1:0] LIMIT = TW'(HOP_LIMIT);

  in_item_t         item;
  logic [POS_W-1:0] frame_pos;
  logic [31:0]      elapsed;
  logic             playing;
  logic [31:0]      loop_count;
  logic [TW-1:0]    trans;
  logic             changed;
  logic             wrapped;
  logic [7:0]       fired;
  logic [1:0]       res_status;
  logic [25:0]      dur_us;

  logic [POS_W-1:0] clip_len;
  logic             bad_delta;
  logic             bad_pos;
  logic             is_adv;
  logic             last_frame;
  logic [32:0]      elapsed_sum;
  logic [31:0]      entry_wide;
  logic [31:0]      pos_wide;
  logic [31:0]      trans_wide;
  logic             ram_we;
  logic [23:0]      ram_rdata;

  assign clip_len    = (frame_count > CLIP_CAP) ? CLIP_CAP : frame_count;
  assign bad_delta   = item.delta_us > DELTA_MAX_US;
  assign bad_pos     = frame_pos >= clip_len;
  assign is_adv      = item.cmd == CMD_ADVANCE;
  assign last_frame  = ({1'b0, frame_pos} + 10'd1) >= {1'b0, clip_len};
  assign elapsed_sum = {1'b0, elapsed} + 33'(item.delta_us);
  assign entry_wide  = 32'(item.entry_index);
  assign pos_wide    = 32'(frame_pos);
  assign trans_wide  = 32'(trans);
  assign ram_we      = cmd.load_wr && (entry_wide < 32'(MAX_FRAMES));

  // one entry holds duration in the upper bits and event id in the lower
  scfs_ram #(
    .WIDTH (24),
    .DEPTH (MAX_FRAMES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_wide[AW-1:0]),
    .wdata ({item.length_ms, item.event_code}),
    .raddr (pos_wide[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts.is_load   = item.cmd == CMD_LOAD;
    sts.is_setpos = item.cmd == CMD_SETPOS;
    sts.adv_run   = is_adv && !bad_delta && !bad_pos && playing && (item.delta_us != '0);
    sts.step_ok   = playing && (trans < LIMIT) && (elapsed >= 32'(dur_us));
    sts.out_busy  = out_valid && !out_ready;
  end

  // play state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pos  <= '0;
      elapsed    <= '0;
      playing    <= 1'b0;
      loop_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.set_pos) begin
        frame_pos <= {1'b0, item.position_index};
        elapsed   <= '0;
        playing   <= item.start_playing;
      end
      if (cmd.adv_begin) begin
        elapsed <= elapsed_sum[32] ? '1 : elapsed_sum[31:0];
      end
      if (cmd.step) begin
        if (!last_frame) begin
          frame_pos <= frame_pos + 9'd1;
          elapsed   <= elapsed - 32'(dur_us);
        end else if (looping) begin
          frame_pos  <= '0;
          loop_count <= loop_count + 32'd1;
          elapsed    <= elapsed - 32'(dur_us);
        end else begin
          frame_pos <= clip_len - 9'd1;
          elapsed   <= '0;
          playing   <= 1'b0;
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // per transaction working values and result register
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item    <= in_data;
      trans   <= '0;
      changed <= 1'b0;
      wrapped <= 1'b0;
      fired   <= '0;
    end
    if (cmd.decode) begin
      priority if (!is_adv) begin
        res_status <= ST_OK;
      end else if (bad_delta) begin
        res_status <= ST_DELTA_BIG;
      end else if (bad_pos) begin
        res_status <= ST_RANGE;
      end else begin
        res_status <= ST_OK;
      end
    end
    if (cmd.mul) begin
      dur_us <= 26'(ram_rdata[23:8] * US_PER_MS);
      // event of the frame just entered
      if ((trans != '0) && (ram_rdata[7:0] != 8'd0)) begin
        fired <= ram_rdata[7:0];
      end
    end
    if (cmd.step) begin
      trans   <= trans + TW'(1);
      changed <= 1'b1;
      if (last_frame && looping) begin
        wrapped <= 1'b1;
      end
    end
    if (cmd.finish) begin
      out_data.status          <= ((res_status == ST_OK) && (trans == LIMIT) && playing)
                                  ? ST_LIMIT : res_status;
      out_data.current_frame   <= frame_pos[7:0];
      out_data.transitions     <= trans_wide[10:0];
      out_data.frame_stepped   <= changed;
      out_data.wrapped         <= wrapped;
      out_data.is_playing      <= playing;
      out_data.fired_event     <= fired;
      out_data.loops_completed <= loop_count;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/scfs_ctrl.sv =====
// controller state machine sequencing decode, table reads and frame steps
`default_nettype none
module scfs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output scfs_pkg::dp_cmd_t      cmd,
  input  wire scfs_pkg::dp_sts_t sts
);
  import scfs_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        priority if (sts.is_load) begin
          cmd.load_wr = 1'b1;
          state_next  = S_DONE;
        end else if (sts.is_setpos) begin
          cmd.set_pos = 1'b1;
          state_next  = S_DONE;
        end else if (sts.adv_run) begin
          cmd.adv_begin = 1'b1;
          state_next    = S_READ;
        end else begin
          state_next = S_DONE;
        end
      end
      // table address follows the frame position, data is back next cycle
      S_READ: begin
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.step_ok) begin
          cmd.step   = 1'b1;
          state_next = S_READ;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sprite_clip_frame_sequencer.sv =====
// top level of the sprite clip frame sequencer: config registers and wiring
//
// channel   direction  handshake              content
// in_ch     sink       valid/ready            load, advance or set-position item
// out_ch    source     valid/ready            one result per input transaction
// apb       slave      psel/penable/pready    frame_count at 0x0, looping at 0x4
//
// load, set position and rejected or idle advance: accepted in idle, decoded, and the
// result registered in the done state
// advance: a loop of table read, duration multiply and elapsed compare/subtract for
// each of its T frame transitions; T is at most HOP_LIMIT
// a new item is taken while the previous result still waits in the output register
// synchronous reset: frame 0, not playing, elapsed and loop count zero,
// frame_count 1, looping 1; the clip table holds no defined contents until loaded
`default_nettype none
module sprite_clip_frame_sequencer #(
  parameter int MAX_FRAMES = scfs_pkg::MAX_FRAMES_DEF,
  parameter int HOP_LIMIT  = scfs_pkg::HOP_LIMIT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  scfs_in_if.sink          in_ch,
  scfs_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import scfs_pkg::*;

  logic [8:0] frame_count;
  logic       looping;
  logic       cfg_wr;
  dp_cmd_t    cmd;
  dp_sts_t    sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? {31'd0, looping} : {23'd0, frame_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= 9'd1;
      looping     <= 1'b1;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        looping <= pwdata[0];
      end else begin
        frame_count <= pwdata[8:0];
      end
    end
  end

  scfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  scfs_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .HOP_LIMIT  (HOP_LIMIT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_data     (in_ch.data),
    .frame_count (frame_count),
    .looping     (looping),
    .out_data    (out_ch.data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready)
  );

endmodule
`default_nettype wire

// ===== verif/clip_result_checker.sv =====
// result checker: follows every transaction of the sequencer and compares each result
module clip_result_checker #(
  parameter logic [2:0] FRAMES_ADDR  = 3'd0,
  parameter logic [2:0] LOOPING_ADDR = 3'd4
) (
  input  logic        clk,
  input  logic        rst,
  scfs_in_if          in_ch,
  scfs_out_if         out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import scfs_pkg::*;

  logic [15:0] frame_ms    [MAX_FRAMES_DEF];
  logic [7:0]  frame_event [MAX_FRAMES_DEF];
  logic [7:0]  head;
  logic [31:0] elapsed;
  logic        running;
  logic [31:0] loops;
  logic [8:0]  frames_reg;
  logic        loop_reg;
  out_item_t   frame_reports [$];

  function automatic out_item_t play_step(input in_item_t it);
    out_item_t   r;
    int unsigned n;
    int unsigned hops;
    logic [31:0] span;
    logic [32:0] sum;
    logic        halt;
    r = '0;
    n = (frames_reg > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : frames_reg;
    case (it.cmd)
      CMD_LOAD: begin
        frame_ms[it.entry_index] = it.length_ms;
        frame_event[it.entry_index] = it.event_code;
      end
      CMD_SETPOS: begin
        head = it.position_index;
        elapsed = '0;
        running = it.start_playing;
      end
      CMD_ADVANCE: begin
        if (it.delta_us > DELTA_MAX_US) begin
          r.status = ST_DELTA_BIG;
        end else if (32'(head) >= n) begin
          r.status = ST_RANGE;
        end else if (running && it.delta_us != '0) begin
          // elapsed time saturates rather than wrapping
          sum = {1'b0, elapsed} + 33'(it.delta_us);
          elapsed = sum[32] ? '1 : sum[31:0];
          hops = 0;
          halt = 1'b0;
          while (running && !halt && hops < HOP_LIMIT_DEF) begin
            span = 32'(frame_ms[head]) * 32'(US_PER_MS);
            if (elapsed < span) begin
              halt = 1'b1;
            end else begin
              elapsed = elapsed - span;
              hops++;
              r.frame_stepped = 1'b1;
              if (32'(head) + 1 < n) begin
                head = head + 8'd1;
              end else if (loop_reg) begin
                head = '0;
                loops = loops + 32'd1;
                r.wrapped = 1'b1;
              end else begin
                // one-shot clip parks on its last frame
                head = 8'(n - 1);
                elapsed = '0;
                running = 1'b0;
              end
              if (frame_event[head] != '0) r.fired_event = frame_event[head];
            end
          end
          if (hops == HOP_LIMIT_DEF && running) r.status = ST_LIMIT;
          r.transitions = 11'(hops);
        end
      end
      default: ;
    endcase
    r.current_frame = head;
    r.is_playing = running;
    r.loops_completed = loops;
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      head = '0;
      elapsed = '0;
      running = 1'b0;
      loops = '0;
      frames_reg = 9'd1;
      loop_reg = 1'b1;
      frame_reports.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == FRAMES_ADDR) frames_reg = pwdata[8:0];
        else if (paddr == LOOPING_ADDR) loop_reg = pwdata[0];
      end
      // results first, so a result never pairs with an item taken at the same edge
      if (out_ch.valid && out_ch.ready) begin
        if (frame_reports.size() == 0) begin
          $error("result transaction with no item pending");
          errors++;
        end else begin
          want = frame_reports.pop_front();
          check_field("status", want.status, out_ch.data.status);
          check_field("current_frame", want.current_frame, out_ch.data.current_frame);
          check_field("transitions", want.transitions, out_ch.data.transitions);
          check_field("frame_stepped", want.frame_stepped, out_ch.data.frame_stepped);
          check_field("wrapped", want.wrapped, out_ch.data.wrapped);
          check_field("is_playing", want.is_playing, out_ch.data.is_playing);
          check_field("fired_event", want.fired_event, out_ch.data.fired_event);
          check_field("loops_completed", want.loops_completed,
                      out_ch.data.loops_completed);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        frame_reports.insert(frame_reports.size(), play_step(in_ch.data));
      end
    end
    outstanding <= frame_reports.size();
  end

endmodule

// ===== verif/testbench.sv =====
// testbench top: clock, reset, item stimulus, channel idling and the final verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import scfs_pkg::*;

  localparam logic [1:0] CMD_SPARE     = 2'd3;
  localparam logic [2:0] FRAMES_ADDR   = 3'd0;
  localparam logic [2:0] LOOPING_ADDR  = 3'd4;
  localparam int         HOLD_CYCLES   = 400;
  localparam int         CYCLE_LIMIT   = 30000000;
  localparam int         SETTLE_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          outstanding;
  int          cycle_count = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  bit          hold_req = 1'b0;
  bit [255:0]  loaded = '0;   // clip entries written so far
  int          frames_set = 1;

  scfs_in_if  in_ch ();
  scfs_out_if out_ch ();

  sprite_clip_frame_sequencer uut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  clip_result_checker #(
    .FRAMES_ADDR  (FRAMES_ADDR),
    .LOOPING_ADDR (LOOPING_ADDR)
  ) chk (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic int clip_len();
    return (frames_set > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : frames_set;
  endfunction

  function automatic in_item_t load_item(input logic [7:0] idx, input logic [15:0] ms,
                                         input logic [7:0] ev);
    in_item_t it;
    it = '0;
    it.cmd = CMD_LOAD;
    it.entry_index = idx;
    it.length_ms = ms;
    it.event_code = ev;
    return it;
  endfunction

  function automatic in_item_t advance_item(input logic [23:0] delta);
    in_item_t it;
    it = '0;
    it.cmd = CMD_ADVANCE;
    it.delta_us = delta;
    return it;
  endfunction

  function automatic in_item_t place_item(input logic [7:0] pos, input logic play);
    in_item_t it;
    it = '0;
    it.cmd = CMD_SETPOS;
    it.position_index = pos;
    it.start_playing = play;
    return it;
  endfunction

  // mostly short frames so that advances step through several of them
  function automatic logic [15:0] random_ms();
    int unsigned pick;
    pick = $urandom_range(31);
    if (pick == 0) return '0;
    if (pick < 3) return 16'($urandom_range(60000));
    return 16'($urandom_range(1, 40));
  endfunction

  function automatic logic [7:0] random_event();
    if ($urandom_range(3) == 0) return '0;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [23:0] random_delta();
    int unsigned pick;
    pick = $urandom_range(63);
    if (pick < 4) return '0;
    if (pick < 8) return 24'($urandom_range(10000001, 16777215));
    if (pick == 8) return DELTA_MAX_US;
    if (pick == 9) return DELTA_MAX_US + 24'd1;
    if (pick < 13) return 24'($urandom_range(10000000));
    return 24'($urandom_range(1, 120000));
  endfunction

  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    int          n;
    n = clip_len();
    // fields that the command does not use still carry noise
    it.entry_index = 8'($urandom_range(255));
    it.length_ms = 16'($urandom_range(60000));
    it.event_code = 8'($urandom_range(255));
    it.delta_us = 24'($urandom_range(16777215));
    it.position_index = 8'($urandom_range(255));
    it.start_playing = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 30) begin
      it.cmd = CMD_LOAD;
      if (n > 0 && $urandom_range(3) != 0) it.entry_index = 8'($urandom_range(n - 1));
      it.length_ms = random_ms();
      it.event_code = random_event();
    end else if (pick < 85) begin
      it.cmd = CMD_ADVANCE;
      it.delta_us = random_delta();
    end else if (pick < 97) begin
      it.cmd = CMD_SETPOS;
      if (n > 0 && $urandom_range(7) != 0) it.position_index = 8'($urandom_range(n - 1));
      it.start_playing = ($urandom_range(7) != 0);
    end else begin
      it.cmd = CMD_SPARE;
    end
    return it;
  endfunction

  task automatic offer(input in_item_t it);
    if (it.cmd == CMD_LOAD) loaded[it.entry_index] = 1'b1;
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic configure(input int frames, input bit loop_on);
    write_reg(FRAMES_ADDR, 32'(frames));
    write_reg(LOOPING_ADDR, 32'(loop_on));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    frames_set = frames;
  endtask

  task automatic run_phase(input int frames, input bit loop_on, input int gap,
                           input int stall, input int count, input bit squeeze);
    wait_drained();
    configure(frames, loop_on);
    gap_pct = gap;
    stall_pct = stall;
    if (squeeze) hold_req = 1'b1;
    // every entry of the clip in use is written before any advance can read it
    for (int i = 0; i < clip_len(); i++) begin
      if (!loaded[i]) offer(load_item(8'(i), random_ms(), random_event()));
    end
    repeat (count) offer(random_item());
  endtask

  initial begin
    in_item_t odd;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset values: one-frame looping clip, stopped at frame 0
    offer(advance_item(24'd0));
    offer(load_item(8'd0, 16'd0, 8'hFF));
    offer(place_item(8'd0, 1'b1));
    offer(advance_item(24'd1));               // zero-length frame spins to the limit
    offer(advance_item(DELTA_MAX_US + 24'd1));
    offer(advance_item(DELTA_MAX_US));
    odd = '1;
    odd.cmd = CMD_SPARE;
    odd.length_ms = 16'd60000;
    offer(odd);
    offer(load_item(8'd0, 16'd60000, 8'd0));
    offer(advance_item(24'hFFFFFF));
    offer(place_item(8'hFF, 1'b0));
    offer(advance_item(24'd7));               // play head beyond the clip
    offer(place_item(8'd0, 1'b1));
    offer(advance_item(DELTA_MAX_US));
    offer(load_item(8'hFF, 16'd1, 8'h80));

    // four-frame one-shot clip with a zero-length frame in the middle
    wait_drained();
    configure(4, 1'b0);
    offer(load_item(8'd0, 16'd2, 8'd1));
    offer(load_item(8'd1, 16'd0, 8'd0));
    offer(load_item(8'd2, 16'd3, 8'd2));
    offer(load_item(8'd3, 16'd1, 8'd0));
    offer(place_item(8'd0, 1'b1));
    offer(advance_item(24'd2000));
    offer(advance_item(24'd4000));            // runs off the end and parks
    offer(advance_item(24'd4000));

    run_phase(256, 1'b1, 0, 0, 260, 1'b1);
    run_phase(1, 1'b1, 64, 0, 220, 1'b0);
    run_phase(511, 1'b0, 0, 64, 260, 1'b0);
    run_phase(0, 1'b1, 36, 36, 120, 1'b0);
    run_phase(17, 1'b1, 0, 0, 260, 1'b0);
    run_phase(256, 1'b0, 36, 36, 260, 1'b0);
    run_phase(5, 1'b1, 0, 64, 250, 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/scfs_pkg.sv
hw/rtl/scfs_if.sv
hw/rtl/scfs_ram.sv
hw/rtl/scfs_datapath.sv
hw/rtl/scfs_ctrl.sv
hw/rtl/sprite_clip_frame_sequencer.sv
verif/clip_result_checker.sv
verif/testbench.sv
